FILE: rtl/shb_pkg.sv
// Shared constants, types and codes of the string hash bucket checker.
// Used by shb_fold and multi_mode_string_hash_bucket_check; no dependencies.
package shb_pkg;

  localparam int unsigned BUCKET_BITS = 11;
  localparam int unsigned MAX_LEN     = 16;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CRC_W   = 16;

  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned BUF_AW = $clog2(MAX_LEN);

  // Occupancy bitmap is stored as rows of ROW_W bits.
  localparam int unsigned ROW_BITS = (BUCKET_BITS >= 6) ? 5 : 2;
  localparam int unsigned ROW_W    = 1 << ROW_BITS;
  localparam int unsigned MAP_AW   = BUCKET_BITS - ROW_BITS;
  localparam int unsigned MAP_ROWS = 1 << MAP_AW;

  localparam int unsigned IN_DATA_W    = ((CHAR_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = BUCKET_BITS + 1 + COUNT_W + 1;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam int unsigned XS_LSHIFT = 13;
  localparam int unsigned XS_RSHIFT = 17;

  typedef enum logic [MODE_W-1:0] {
    MODE_MUL33    = 2'd0,
    MODE_SHXOR    = 2'd1,
    MODE_CRC16    = 2'd2,
    MODE_XORSHIFT = 2'd3
  } hash_mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_REPLAY,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  // Request to the fold unit for one character.
  typedef struct packed {
    hash_mode_e        mode;
    logic              start;
    logic [CHAR_W-1:0] char_code;
  } fold_req_t;

  // Result word, last field (bucket) in the lowest bits.
  typedef struct packed {
    logic                   too_long;
    logic [COUNT_W-1:0]     collision_count;
    logic                   collided;
    logic [BUCKET_BITS-1:0] bucket;
  } result_t;

endpackage

FILE: rtl/shb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module shb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/shb_fold.sv
// Hash fold unit: folds one character into the accumulator under the selected
// mode, and performs one xorshift replay step. Depends on shb_pkg.
module shb_fold (
  input  shb_pkg::fold_req_t             req_i,
  input  logic [shb_pkg::HASH_W-1:0]     acc_i,
  input  logic [shb_pkg::CHAR_W-1:0]     xs_next_i,
  output logic [shb_pkg::HASH_W-1:0]     fold_o,
  output logic [shb_pkg::HASH_W-1:0]     xs_step_o
);

  logic [shb_pkg::HASH_W-1:0]        base;
  logic [shb_pkg::HASH_W-1:0]        char_ext;
  logic [shb_pkg::CRC_W-1:0]         crc;
  logic [7:0]                        crc_x;
  logic [shb_pkg::CRC_W-1:0]         crc_x_ext;
  logic [shb_pkg::CRC_W-1:0]         crc_next;
  logic [shb_pkg::HASH_W-1:0]        xs_t;
  logic signed [shb_pkg::HASH_W-1:0] xs_s;

  always_comb begin
    // Start of string: load the mode's initial value instead of the accumulator.
    if (req_i.start) begin
      base = (req_i.mode == shb_pkg::MODE_CRC16) ?
             shb_pkg::HASH_W'(shb_pkg::CRC_INIT) : '0;
    end else begin
      base = acc_i;
    end
    char_ext = shb_pkg::HASH_W'(req_i.char_code);

    crc       = base[shb_pkg::CRC_W-1:0];
    crc_x     = crc[15:8] ^ 8'(req_i.char_code);
    crc_x     = crc_x ^ (crc_x >> 4);
    crc_x_ext = shb_pkg::CRC_W'(crc_x);
    crc_next  = (crc << 8) ^ (crc_x_ext << 12) ^ (crc_x_ext << 5) ^ crc_x_ext;

    case (req_i.mode)
      shb_pkg::MODE_MUL33:    fold_o = (base << 5) + base + char_ext;
      shb_pkg::MODE_SHXOR:    fold_o = ((base << 3) ^ base) + char_ext;
      shb_pkg::MODE_CRC16:    fold_o = shb_pkg::HASH_W'(crc_next);
      shb_pkg::MODE_XORSHIFT: fold_o = (base << 5) - base + char_ext;
      default:                fold_o = base;
    endcase
  end

  always_comb begin
    xs_t      = acc_i ^ (acc_i << shb_pkg::XS_LSHIFT);
    xs_s      = xs_t;
    xs_t      = xs_t ^ shb_pkg::HASH_W'(xs_s >>> shb_pkg::XS_RSHIFT);
    xs_step_o = xs_t ^ shb_pkg::HASH_W'(xs_next_i);
  end

endmodule

FILE: rtl/multi_mode_string_hash_bucket_check.sv
// String hash bucket checker, top level.
// Depends on shb_pkg, shb_fold and shb_ram (character buffer and occupancy map).
//
// Usage:
//   The slave stream takes one word per character: tdata[6:0] the character,
//   tuser the action (1 = hash, 0 = clear bitmap and count), tlast marks the
//   final character of a string. The master stream returns one word per
//   finished string: bucket, collided flag, collision count, too_long flag.
//   The cfg channel writes the 2-bit hash mode; it is always ready.
//   Throughput: one character per cycle for every character but the last.
//   The last character of a string holds the input off while the map row
//   is read (LOOKUP) and then read-modified-written (UPDATE); its result is
//   registered in UPDATE. In the xorshift mode the end-of-string replay adds
//   a PREP state and then one xorshift step per buffered character, one step
//   per cycle, against the character buffer read port. A string too long for
//   the 16-entry buffer in that mode goes straight to UPDATE and yields a
//   too_long result there, with nothing marked.
//   Clear sweeps the occupancy map one 32-bit row per cycle, all 64 rows,
//   with the input held off. Reset starts the same clearing pass.
//   A result waits in the output register while the receiver stalls; the
//   block keeps taking characters and stalls only when the next result
//   would overwrite an untaken one.
module multi_mode_string_hash_bucket_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [shb_pkg::MODE_W-1:0]       cfg_data_i,     // hash_mode
  // character stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [shb_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // char_code, zero pad
  input  logic                             s_axis_tuser,   // action
  input  logic                             s_axis_tlast,   // last_char
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [shb_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // bucket, collided,
                                                           // collision_count,
                                                           // too_long, zero pad
);

  shb_pkg::state_e   state_q, state_d;
  shb_pkg::hash_mode_e hash_mode_q;

  logic [shb_pkg::HASH_W-1:0]  acc_q, acc_d;
  logic [shb_pkg::LEN_W-1:0]   len_q, len_d;
  logic                        ovf_q, ovf_d;
  logic [shb_pkg::COUNT_W-1:0] count_q, count_d;
  logic [shb_pkg::MAP_AW-1:0]  clr_row_q, clr_row_d;
  logic [shb_pkg::LEN_W-1:0]   rep_idx_q, rep_idx_d;
  logic                        too_long_q, too_long_d;
  logic                        out_valid_q, out_valid_d;
  shb_pkg::result_t            out_q, out_d;

  // handshake and decode
  logic in_fire;
  logic out_free;
  logic len_full;
  logic ovf_next;
  logic [shb_pkg::LEN_W:0] idx1;
  logic [shb_pkg::LEN_W:0] idx2;
  logic                    rep_done;

  // fold unit
  shb_pkg::fold_req_t         fold_req;
  logic [shb_pkg::HASH_W-1:0] fold_acc;
  logic [shb_pkg::HASH_W-1:0] xs_step;
  logic [shb_pkg::CHAR_W-1:0] xs_next;

  // memories
  logic                         buf_we;
  logic [shb_pkg::BUF_AW-1:0]   buf_waddr;
  logic [shb_pkg::BUF_AW-1:0]   buf_raddr;
  logic [shb_pkg::CHAR_W-1:0]   buf_rdata;
  logic                         map_we;
  logic [shb_pkg::MAP_AW-1:0]   map_waddr;
  logic [shb_pkg::ROW_W-1:0]    map_wdata;
  logic [shb_pkg::MAP_AW-1:0]   map_raddr;
  logic [shb_pkg::ROW_W-1:0]    map_rdata;
  logic [shb_pkg::ROW_BITS-1:0] map_bit;
  logic                         hit;
  logic [shb_pkg::COUNT_W-1:0]  count_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == shb_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_valid_q | m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = shb_pkg::OUT_DATA_W'(out_q);

  // A character that finds the buffer full is dropped from it and flags overflow.
  assign len_full = (len_q == shb_pkg::LEN_W'(shb_pkg::MAX_LEN));
  assign ovf_next = ovf_q | len_full;

  // Replay step i folds in buffer entry i+1; entry i+2 is read ahead.
  assign idx1     = {1'b0, rep_idx_q} + (shb_pkg::LEN_W + 1)'(1);
  assign idx2     = {1'b0, rep_idx_q} + (shb_pkg::LEN_W + 1)'(2);
  assign rep_done = (idx1 == {1'b0, len_q});
  assign xs_next  = (idx1 < {1'b0, len_q}) ? buf_rdata : '0;

  assign fold_req.mode      = hash_mode_q;
  assign fold_req.start     = (len_q == '0) & !ovf_q;
  assign fold_req.char_code = s_axis_tdata[shb_pkg::CHAR_W-1:0];

  // Occupancy lookup always addresses the row of the finished hash.
  assign map_raddr = acc_q[shb_pkg::BUCKET_BITS-1:shb_pkg::ROW_BITS];
  assign map_bit   = acc_q[shb_pkg::ROW_BITS-1:0];
  assign hit       = map_rdata[map_bit];
  assign count_inc = (hit && count_q != '1) ? count_q + shb_pkg::COUNT_W'(1) : count_q;

  assign buf_waddr = len_q[shb_pkg::BUF_AW-1:0];

  shb_fold u_fold (
    .req_i     (fold_req),
    .acc_i     (acc_q),
    .xs_next_i (xs_next),
    .fold_o    (fold_acc),
    .xs_step_o (xs_step)
  );

  shb_ram #(
    .WIDTH (shb_pkg::CHAR_W),
    .DEPTH (shb_pkg::MAX_LEN)
  ) u_char_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (fold_req.char_code),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  shb_ram #(
    .WIDTH (shb_pkg::ROW_W),
    .DEPTH (shb_pkg::MAP_ROWS)
  ) u_occ_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      shb_pkg::ST_CLEAR: begin
        if (&clr_row_q) begin
          state_d = shb_pkg::ST_IDLE;
        end
      end
      shb_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!s_axis_tuser) begin
            state_d = shb_pkg::ST_CLEAR;
          end else if (s_axis_tlast) begin
            if (hash_mode_q != shb_pkg::MODE_XORSHIFT) begin
              state_d = shb_pkg::ST_LOOKUP;
            end else if (ovf_next) begin
              state_d = shb_pkg::ST_UPDATE;
            end else begin
              state_d = shb_pkg::ST_PREP;
            end
          end
        end
      end
      shb_pkg::ST_PREP:   state_d = shb_pkg::ST_REPLAY;
      shb_pkg::ST_REPLAY: begin
        if (rep_done) begin
          state_d = shb_pkg::ST_LOOKUP;
        end
      end
      shb_pkg::ST_LOOKUP: state_d = shb_pkg::ST_UPDATE;
      shb_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_d = shb_pkg::ST_IDLE;
        end
      end
      default:            state_d = shb_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    acc_d       = acc_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    count_d     = count_q;
    clr_row_d   = clr_row_q;
    rep_idx_d   = rep_idx_q;
    too_long_d  = too_long_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    buf_we      = 1'b0;
    buf_raddr   = '0;
    map_we      = 1'b0;
    map_waddr   = map_raddr;
    map_wdata   = '0;

    // Drop the held result once taken.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      shb_pkg::ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_row_q;
        clr_row_d = clr_row_q + shb_pkg::MAP_AW'(1);
      end
      shb_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!s_axis_tuser) begin
            // Clear leaves any string in progress alone.
            count_d   = '0;
            clr_row_d = '0;
          end else begin
            acc_d = fold_acc;
            if (!len_full) begin
              buf_we = 1'b1;
              len_d  = len_q + shb_pkg::LEN_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
            too_long_d = (hash_mode_q == shb_pkg::MODE_XORSHIFT) & ovf_next;
            rep_idx_d  = '0;
          end
        end
      end
      shb_pkg::ST_PREP: begin
        buf_raddr = shb_pkg::BUF_AW'(1);
      end
      shb_pkg::ST_REPLAY: begin
        acc_d     = xs_step;
        rep_idx_d = idx1[shb_pkg::LEN_W-1:0];
        if (idx2 < {1'b0, len_q}) begin
          buf_raddr = idx2[shb_pkg::BUF_AW-1:0];
        end
      end
      shb_pkg::ST_LOOKUP: begin
        // Wait for the map row.
      end
      shb_pkg::ST_UPDATE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (too_long_q) begin
            out_d.bucket          = '0;
            out_d.collided        = 1'b0;
            out_d.collision_count = count_q;
            out_d.too_long        = 1'b1;
          end else begin
            map_we                = 1'b1;
            map_wdata             = map_rdata | (shb_pkg::ROW_W'(1) << map_bit);
            count_d               = count_inc;
            out_d.bucket          = acc_q[shb_pkg::BUCKET_BITS-1:0];
            out_d.collided        = hit;
            out_d.collision_count = count_inc;
            out_d.too_long        = 1'b0;
          end
          acc_d = '0;
          len_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: begin
        clr_row_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shb_pkg::ST_CLEAR;
      hash_mode_q <= shb_pkg::MODE_MUL33;
      acc_q       <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      clr_row_q   <= '0;
      rep_idx_q   <= '0;
      too_long_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        hash_mode_q <= shb_pkg::hash_mode_e'(cfg_data_i);
      end
      acc_q       <= acc_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      count_q     <= count_d;
      clr_row_q   <= clr_row_d;
      rep_idx_q   <= rep_idx_d;
      too_long_q  <= too_long_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Replay never steps past the buffered characters.
  a_replay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shb_pkg::ST_REPLAY |-> rep_idx_q < len_q)
    else $error("replay index beyond string length");

  // Buffer fill count stays within the buffer.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= shb_pkg::LEN_W'(shb_pkg::MAX_LEN))
    else $error("string length beyond buffer depth");

  // Count only drops on a clear.
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && !s_axis_tuser) |=> count_q >= $past(count_q))
    else $error("collision count dropped without clear");

  // An overlong string never marks the map.
  a_too_long_no_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == shb_pkg::ST_UPDATE && too_long_q) |-> !map_we)
    else $error("overlong string marked the occupancy map");

endmodule

FILE: dv/multi_mode_string_hash_bucket_check_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_mode_string_hash_bucket_check.
// Drives strings through the character stream, predicts each bucket report and compares.
// Depends on shb_pkg and the block's RTL only.
module multi_mode_string_hash_bucket_check_test;
  import shb_pkg::*;

  // action codes carried in tuser
  localparam bit ACT_CLEAR = 1'b0;
  localparam bit ACT_HASH  = 1'b1;

  // Longest quiet time the block may still need once the last report is out:
  // a 64-row map sweep, or a full-buffer replay plus the map update.
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_CHARS  = 1700;
  // One-character strings sent back to back at the end of the run.
  localparam int SOAK_STRINGS  = 300;
  localparam int MAX_PRINTS    = 40;
  localparam int DIR_ROWS      = 22;

  typedef enum {ROW_HASH, ROW_CLEAR, ROW_MODE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CHAR_W-1:0] ch;
    bit                lst;
    int                reps;    // repeat the word this many times
    hash_mode_e        mode;    // used by ROW_MODE only
    bit                pinned;  // report typed in below instead of predicted
    result_t           want;    // {too_long, collision_count, collided, bucket}
  } stim_row_t;

  localparam result_t NO_REPORT = '0;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [MODE_W-1:0]      cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  multi_mode_string_hash_bucket_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Directed strings. Typed reports are the ones readable at a glance: in mode 0 a
  // one-character string lands in the bucket equal to its code.
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_HASH,  7'd65,  1'b1, 1,  MODE_MUL33,    1'b1, {1'b0, 16'd0, 1'b0, 11'd65}},
    '{ROW_HASH,  7'd65,  1'b1, 1,  MODE_MUL33,    1'b1, {1'b0, 16'd1, 1'b1, 11'd65}},
    '{ROW_HASH,  7'd127, 1'b1, 1,  MODE_MUL33,    1'b1, {1'b0, 16'd1, 1'b0, 11'd127}},
    '{ROW_HASH,  7'd0,   1'b1, 1,  MODE_MUL33,    1'b1, {1'b0, 16'd1, 1'b0, 11'd0}},
    // zero code inside a string does not end it
    '{ROW_HASH,  7'd0,   1'b0, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_HASH,  7'd127, 1'b1, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_MODE,  7'd0,   1'b0, 1,  MODE_SHXOR,    1'b0, NO_REPORT},
    '{ROW_HASH,  7'd1,   1'b0, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_HASH,  7'd127, 1'b1, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_MODE,  7'd0,   1'b0, 1,  MODE_CRC16,    1'b0, NO_REPORT},
    '{ROW_HASH,  7'd65,  1'b1, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    // switch from crc to xorshift halfway through a string
    '{ROW_HASH,  7'd88,  1'b0, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_MODE,  7'd0,   1'b0, 1,  MODE_XORSHIFT, 1'b0, NO_REPORT},
    '{ROW_HASH,  7'd89,  1'b1, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    // clear in the middle of a string leaves the string alone
    '{ROW_HASH,  7'd3,   1'b0, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_CLEAR, 7'd127, 1'b1, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_HASH,  7'd4,   1'b1, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    // seventeen characters overflow the buffer: flagged, nothing marked
    '{ROW_HASH,  7'd127, 1'b0, 16, MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_HASH,  7'd1,   1'b1, 1,  MODE_MUL33,    1'b1, {1'b1, 16'd0, 1'b0, 11'd0}},
    '{ROW_HASH,  7'd2,   1'b1, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_MODE,  7'd0,   1'b0, 1,  MODE_MUL33,    1'b0, NO_REPORT},
    '{ROW_HASH,  7'd65,  1'b1, 1,  MODE_MUL33,    1'b0, NO_REPORT}
  };

  // Shadow of the block: running hash, buffered characters, bitmap and hit count.
  hash_mode_e                cur_mode;
  logic [HASH_W-1:0]         run_hash;
  logic [CHAR_W-1:0]         run_chars [MAX_LEN];
  int                        run_len;
  bit                        run_spill;
  bit [(1<<BUCKET_BITS)-1:0] seen_map;
  logic [COUNT_W-1:0]        hit_total;

  result_t bucket_reports_q [$];
  int      mismatches;
  int      gap_pct;
  int      stall_pct;
  bit      pin_en;
  result_t pin_res;

  // CRC-16-CCITT (poly 0x1021), one byte folded in per call.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [CHAR_W-1:0] ch);
    logic [CRC_W-1:0] x;
    x = (crc >> 8) ^ CRC_W'(ch);
    x = x ^ (x >> 4);
    return (crc << 8) ^ (x << 12) ^ (x << 5) ^ x;
  endfunction

  // Fold one accepted word into the shadow state; hand back a report on the last character.
  task automatic hash_and_probe(input bit act, input logic [CHAR_W-1:0] ch, input bit lst,
                                output bit has_rep, output result_t rep);
    logic [HASH_W-1:0]        s;
    logic signed [HASH_W-1:0] t;
    logic [BUCKET_BITS-1:0]   b;
    int                       k;
    has_rep = 1'b0;
    rep = '0;
    if (act == ACT_CLEAR) begin
      seen_map = '0;
      hit_total = '0;
      return;
    end
    if (run_len == 0 && !run_spill) begin
      run_hash = (cur_mode == MODE_CRC16) ? HASH_W'(CRC_INIT) : '0;
    end
    case (cur_mode)
      MODE_MUL33: run_hash = run_hash * 64'd33 + HASH_W'(ch);
      MODE_SHXOR: run_hash = ((run_hash << 3) ^ run_hash) + HASH_W'(ch);
      MODE_CRC16: run_hash = HASH_W'(crc_byte(run_hash[CRC_W-1:0], ch));
      default:    run_hash = run_hash * 64'd31 + HASH_W'(ch);
    endcase
    if (run_len < MAX_LEN) begin
      run_chars[run_len] = ch;
      run_len++;
    end else begin
      run_spill = 1'b1;
    end
    if (!lst) return;

    has_rep = 1'b1;
    if (cur_mode == MODE_XORSHIFT && run_spill) begin
      rep.too_long = 1'b1;
      rep.collision_count = hit_total;
    end else begin
      s = run_hash;
      if (cur_mode == MODE_XORSHIFT) begin
        // replay: one xorshift per buffered character, mixing in the next one
        for (k = 0; k < run_len; k++) begin
          s = s ^ (s << XS_LSHIFT);
          t = s;
          t = t >>> XS_RSHIFT;
          s = s ^ t;
          if (k + 1 < run_len) s = s ^ HASH_W'(run_chars[k+1]);
        end
      end
      b = s[BUCKET_BITS-1:0];
      rep.bucket = b;
      if (seen_map[b]) begin
        rep.collided = 1'b1;
        if (hit_total != '1) hit_total++;
      end
      seen_map[b] = 1'b1;
      rep.collision_count = hit_total;
    end
    run_len = 0;
    run_spill = 1'b0;
    run_hash = '0;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Track handshakes at the rising edge: predict on input words, compare on output words.
  always @(posedge clk_i) begin : scoreboard
    bit      has_rep;
    result_t rep;
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) cur_mode = hash_mode_e'(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        hash_and_probe(s_axis_tuser, s_axis_tdata[CHAR_W-1:0], s_axis_tlast, has_rep, rep);
        if (has_rep) bucket_reports_q.push_back(pin_en ? pin_res : rep);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
        if (bucket_reports_q.size() == 0) begin
          flag_mismatch("unexpected report word", 32'(got), 32'd0);
        end else begin
          want = bucket_reports_q.pop_front();
          if (got.bucket !== want.bucket)
            flag_mismatch("bucket", 32'(got.bucket), 32'(want.bucket));
          if (got.collided !== want.collided)
            flag_mismatch("collided", 32'(got.collided), 32'(want.collided));
          if (got.collision_count !== want.collision_count)
            flag_mismatch("collision_count", 32'(got.collision_count),
                          32'(want.collision_count));
          if (got.too_long !== want.too_long)
            flag_mismatch("too_long", 32'(got.too_long), 32'(want.too_long));
        end
      end
    end
  end

  // Offer one character word; hold it until taken. Enter and leave at a falling edge.
  task automatic send_word(input bit act, input logic [CHAR_W-1:0] ch, input bit lst,
                           input bit pin, input result_t prep);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(ch);
    s_axis_tuser  <= act;
    s_axis_tlast  <= lst;
    pin_en  = pin;
    pin_res = prep;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid, drain every pending report, then give the block time to finish sweeps.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (bucket_reports_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(input hash_mode_e m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: stall in random bursts while stall_pct is nonzero.
  initial begin : report_sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    int done;
    int len;
    int r;
    int k;
    cur_mode      = MODE_MUL33;
    run_hash      = '0;
    run_len       = 0;
    run_spill     = 1'b0;
    seen_map      = '0;
    hit_total     = '0;
    mismatches    = 0;
    pin_en        = 1'b0;
    pin_res       = '0;
    gap_pct       = 10;
    stall_pct     = 5;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = MODE_MUL33;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_CLEAR;
    s_axis_tlast  = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_MODE: begin
          settle();
          write_mode(dir_tab[i].mode);
        end
        ROW_CLEAR: begin
          send_word(ACT_CLEAR, dir_tab[i].ch, dir_tab[i].lst, 1'b0, NO_REPORT);
        end
        default: begin
          repeat (dir_tab[i].reps)
            send_word(ACT_HASH, dir_tab[i].ch, dir_tab[i].lst, dir_tab[i].pinned,
                      dir_tab[i].want);
        end
      endcase
    end

    // random strings: mostly short, a quarter around the buffer size to hit overflow
    done = 0;
    while (done < RANDOM_CHARS) begin
      if (done < 700) begin
        gap_pct = 20;
        stall_pct = 5;
      end else if (done < 1200) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = 40;
        stall_pct = 15;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_word(ACT_CLEAR, CHAR_W'($urandom_range(0, 127)), $urandom_range(0, 1) == 1,
                  1'b0, NO_REPORT);
        done++;
      end else if (r < 8) begin
        settle();
        write_mode(hash_mode_e'($urandom_range(0, 3)));
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_LEN - 1, MAX_LEN + 3)
                                          : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 59) == 0) begin
            send_word(ACT_CLEAR, CHAR_W'($urandom_range(0, 127)),
                      $urandom_range(0, 1) == 1, 1'b0, NO_REPORT);
            done++;
          end
          // change mode with a string half done
          if ($urandom_range(0, 99) == 0) begin
            settle();
            write_mode(hash_mode_e'($urandom_range(0, 3)));
          end
          send_word(ACT_HASH, CHAR_W'($urandom_range(0, 127)), k == len - 1, 1'b0,
                    NO_REPORT);
          done++;
        end
      end
    end

    // Closing run without idling: one-character strings after a clear.
    gap_pct = 0;
    stall_pct = 0;
    settle();
    write_mode(MODE_MUL33);
    send_word(ACT_CLEAR, '0, 1'b0, 1'b0, NO_REPORT);
    repeat (SOAK_STRINGS)
      send_word(ACT_HASH, CHAR_W'($urandom_range(0, 127)), 1'b1, 1'b0, NO_REPORT);
    settle();

    if (mismatches == 0) begin
      $display("multi_mode_string_hash_bucket_check regression: pass");
    end else begin
      $display("multi_mode_string_hash_bucket_check regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("multi_mode_string_hash_bucket_check regression: fail");
    $finish;
  end

endmodule
